// ===== rtl/core/psrp_pkg.sv =====
// ----------------------------------------------------------------------------
// psrp_pkg
// Shared types and constants for the sensor report parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package psrp_pkg;

   localparam int VALUE_COUNT_DEFAULT   = 9;
   localparam int CHANNEL_COUNT_DEFAULT = 3;

   localparam int WORD_BITS         = 32;
   localparam int WORDS_PER_CHANNEL = 3;
   localparam int CHANNEL_BITS      = WORD_BITS * WORDS_PER_CHANNEL;

   localparam logic [6:0] DATA_MASK   = 7'h7f;
   localparam logic [6:0] SHIFT_STEP  = 7'd7;
   localparam logic [6:0] SHIFT_LIMIT = 7'd64;

   localparam logic [2:0]  WT_VARINT      = 3'd0;
   localparam logic [2:0]  WT_LEN         = 3'd2;
   localparam logic [31:0] FIELD_PAYLOAD  = 32'd1;
   localparam logic [31:0] FIELD_ACCURACY = 32'd2;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_MALFORMED = 2'd1,
      ST_LENGTH    = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] byte_in;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  channel_index;
      logic [31:0] delta_bits;
      logic [31:0] raw_bits;
      logic [31:0] baseline_bits;
      logic [31:0] accuracy_out;
      logic [1:0]  status;
      logic        last_result;
   } rsp_type;

   // parser to result stage, one per finished report
   typedef struct packed {
      logic        done;
      status_type  status;
      logic [31:0] accuracy;
   } report_type;

endpackage

`default_nettype wire

// ===== rtl/core/psrp_parser.sv =====
// ----------------------------------------------------------------------------
// psrp_parser
// Byte-wide wire format parser: varints, field dispatch, payload capture.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psrp_parser
   import psrp_pkg::*;
#(
   parameter int VALUE_COUNT = VALUE_COUNT_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            in_accept,
   input  wire req_type                         in_req,
   output      logic [VALUE_COUNT*WORD_BITS-1:0] payload_out,
   output      report_type                      report_out
);

   localparam int PAYLOAD_BYTES = VALUE_COUNT * 4;
   localparam int PAY_W         = VALUE_COUNT * WORD_BITS;
   localparam int CNT_W         = $clog2(PAYLOAD_BYTES + 2);

   typedef enum logic [4:0] {
      PH_KEY   = 5'b00001,
      PH_VALUE = 5'b00010,
      PH_LEN   = 5'b00100,
      PH_BODY  = 5'b01000,
      PH_DEAD  = 5'b10000
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [63:0]      accum_ff, accum_in;
   logic [6:0]       shift_ff, shift_in;
   logic [31:0]      field_ff, field_in;
   logic [63:0]      skip_ff, skip_in;
   logic             capture_ff, capture_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PAY_W-1:0] pay_ff, pay_in;
   logic [31:0]      acc_ff, acc_in;
   logic             mal_ff, mal_in;

   logic [63:0] vint;
   logic [6:0]  shift_sum;
   logic        bad_end;

   assign vint      = accum_ff | (64'({57'd0, in_req.byte_in[6:0] & DATA_MASK}) << shift_ff);
   assign shift_sum = shift_ff + SHIFT_STEP;

   always_comb begin
      phase_in   = phase_ff;
      accum_in   = accum_ff;
      shift_in   = shift_ff;
      field_in   = field_ff;
      skip_in    = skip_ff;
      capture_in = capture_ff;
      count_in   = count_ff;
      pay_in     = pay_ff;
      acc_in     = acc_ff;
      mal_in     = mal_ff;
      report_out = '0;
      bad_end    = 1'b0;

      if (in_accept) begin
         unique case (phase_ff) inside
            PH_KEY, PH_VALUE, PH_LEN: begin
               if (in_req.byte_in[7]) begin
                  accum_in = vint;
                  shift_in = shift_sum;
                  if (shift_sum >= SHIFT_LIMIT) begin
                     mal_in   = 1'b1;
                     phase_in = PH_DEAD;
                  end
               end else begin
                  accum_in = '0;
                  shift_in = '0;
                  if (phase_ff == PH_KEY) begin
                     field_in = vint[34:3];
                     case (vint[2:0])
                        WT_VARINT: phase_in = PH_VALUE;
                        WT_LEN:    phase_in = PH_LEN;
                        default: begin
                           mal_in   = 1'b1;
                           phase_in = PH_DEAD;
                        end
                     endcase
                  end else if (phase_ff == PH_VALUE) begin
                     if (field_ff == FIELD_ACCURACY) begin
                        acc_in = vint[31:0];
                     end
                     phase_in = PH_KEY;
                  end else begin
                     capture_in = (field_ff == FIELD_PAYLOAD);
                     if (field_ff == FIELD_PAYLOAD) begin
                        count_in = '0;
                     end
                     skip_in  = vint;
                     phase_in = (vint != 64'd0) ? PH_BODY : PH_KEY;
                  end
               end
            end
            PH_BODY: begin
               if (capture_ff) begin
                  if (count_ff < CNT_W'(PAYLOAD_BYTES)) begin
                     pay_in = {in_req.byte_in, pay_ff[PAY_W-1:8]};
                  end
                  if (count_ff <= CNT_W'(PAYLOAD_BYTES)) begin
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               skip_in = skip_ff - 64'd1;
               if (skip_ff == 64'd1) begin
                  phase_in = PH_KEY;
               end
            end
            PH_DEAD: begin
            end
            default: begin
            end
         endcase

         if (in_req.last_byte) begin
            bad_end             = mal_in || (phase_in != PH_KEY) || (shift_in != 7'd0);
            report_out.done     = 1'b1;
            report_out.accuracy = acc_in;
            if (bad_end) begin
               report_out.status = ST_MALFORMED;
            end else if (count_in != CNT_W'(PAYLOAD_BYTES)) begin
               report_out.status = ST_LENGTH;
            end else begin
               report_out.status = ST_OK;
            end
            phase_in   = PH_KEY;
            accum_in   = '0;
            shift_in   = '0;
            field_in   = '0;
            skip_in    = '0;
            capture_in = 1'b0;
            count_in   = '0;
            acc_in     = '0;
            mal_in     = 1'b0;
         end
      end
   end

   // payload seen by the result stage includes the current byte
   assign payload_out = pay_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_KEY;
         accum_ff   <= '0;
         shift_ff   <= '0;
         field_ff   <= '0;
         skip_ff    <= '0;
         capture_ff <= 1'b0;
         count_ff   <= '0;
         acc_ff     <= '0;
         mal_ff     <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         accum_ff   <= accum_in;
         shift_ff   <= shift_in;
         field_ff   <= field_in;
         skip_ff    <= skip_in;
         capture_ff <= capture_in;
         count_ff   <= count_in;
         acc_ff     <= acc_in;
         mal_ff     <= mal_in;
      end
   end

   always_ff @(posedge clock) begin
      pay_ff <= pay_in;
   end

endmodule

`default_nettype wire

// ===== rtl/core/psrp_emitter.sv =====
// ----------------------------------------------------------------------------
// psrp_emitter
// Result register: holds a finished report and walks its channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psrp_emitter
   import psrp_pkg::*;
#(
   parameter int VALUE_COUNT   = VALUE_COUNT_DEFAULT,
   parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire report_type                       report_in,
   input  wire logic [VALUE_COUNT*WORD_BITS-1:0] payload_in,
   output      logic                             free_out,
   output      logic                             rsp_valid,
   input  wire logic                             rsp_stall,
   output      rsp_type                          rsp_payload
);

   localparam int PAY_W = VALUE_COUNT * WORD_BITS;
   localparam int CHW   = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

   logic             valid_ff, valid_in;
   logic [CHW-1:0]   chan_ff, chan_in;
   status_type       status_ff, status_in;
   logic [31:0]      acc_ff, acc_in;
   logic [PAY_W-1:0] bank_ff, bank_in;

   logic take;
   logic final_w;

   assign final_w  = (status_ff != ST_OK) || (chan_ff == CHW'(CHANNEL_COUNT - 1));
   assign take     = valid_ff && !rsp_stall;
   assign free_out = !valid_ff || (take && final_w);

   always_comb begin
      valid_in  = valid_ff;
      chan_in   = chan_ff;
      status_in = status_ff;
      acc_in    = acc_ff;
      bank_in   = bank_ff;
      if (report_in.done) begin
         valid_in  = 1'b1;
         chan_in   = '0;
         status_in = report_in.status;
         acc_in    = (report_in.status == ST_OK) ? report_in.accuracy : 32'd0;
         bank_in   = (report_in.status == ST_OK) ? payload_in : '0;
      end else if (take) begin
         if (final_w) begin
            valid_in = 1'b0;
         end else begin
            chan_in = chan_ff + CHW'(1);
            bank_in = bank_ff >> CHANNEL_BITS;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         chan_ff   <= '0;
         status_ff <= ST_OK;
      end else begin
         valid_ff  <= valid_in;
         chan_ff   <= chan_in;
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      bank_ff <= bank_in;
   end

   assign rsp_valid                 = valid_ff;
   assign rsp_payload.channel_index = 2'(chan_ff);
   assign rsp_payload.delta_bits    = bank_ff[WORD_BITS-1:0];
   assign rsp_payload.raw_bits      = bank_ff[2*WORD_BITS-1:WORD_BITS];
   assign rsp_payload.baseline_bits = bank_ff[3*WORD_BITS-1:2*WORD_BITS];
   assign rsp_payload.accuracy_out  = acc_ff;
   assign rsp_payload.status        = status_ff;
   assign rsp_payload.last_result   = final_w;

endmodule

`default_nettype wire

// ===== rtl/core/protobuf_sensor_report_parser.sv =====
// ----------------------------------------------------------------------------
// protobuf_sensor_report_parser
// Parses a byte stream of sensor reports and emits per-channel results.
// ----------------------------------------------------------------------------
//  port group   direction  contents
//  req_*        in         one report byte and its last-byte flag
//  rsp_*        out        one channel result, or one error result
//
//  One byte is taken per cycle unless stalled; parse state updates in that cycle.
//  The last byte of a report loads the result register; results follow one per
//  cycle unless stalled, from the next cycle: CHANNEL_COUNT, or one error result.
//  Bytes of the next report keep flowing while results drain; only its last
//  byte is held (req_stall) until the previous report's final result is taken.
//  Synchronous reset returns the parser to key parsing and empties the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module protobuf_sensor_report_parser
   import psrp_pkg::*;
#(
   parameter int VALUE_COUNT   = VALUE_COUNT_DEFAULT,
   parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_stall,
   input  wire req_type req_payload,
   output      logic    rsp_valid,
   input  wire logic    rsp_stall,
   output      rsp_type rsp_payload
);

   logic [VALUE_COUNT*WORD_BITS-1:0] payload;
   report_type                       report;
   logic                             out_free;
   logic                             accept;

   assign req_stall = req_payload.last_byte && !out_free;
   assign accept    = req_valid && !req_stall;

   psrp_parser #(
      .VALUE_COUNT (VALUE_COUNT)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .in_accept   (accept),
      .in_req      (req_payload),
      .payload_out (payload),
      .report_out  (report)
   );

   psrp_emitter #(
      .VALUE_COUNT   (VALUE_COUNT),
      .CHANNEL_COUNT (CHANNEL_COUNT)
   ) u_emitter (
      .clock       (clock),
      .reset       (reset),
      .report_in   (report),
      .payload_in  (payload),
      .free_out    (out_free),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// ===== rtl/core/psrp_checker.sv =====
// ----------------------------------------------------------------------------
// psrp_checker
// Port-level checks for the sensor report parser, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psrp_checker
   import psrp_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire req_type req_payload,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_payload
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   // error results are single and zeroed
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status != ST_OK) |->
         rsp_payload.last_result && (rsp_payload.channel_index == 2'd0) &&
         (rsp_payload.delta_bits == 32'd0) && (rsp_payload.raw_bits == 32'd0) &&
         (rsp_payload.baseline_bits == 32'd0) && (rsp_payload.accuracy_out == 32'd0))
      else $error("error result not zeroed");

   // channels of one report follow in order with the same accuracy
   a_chan_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_payload.last_result |=>
         rsp_valid && (rsp_payload.status == ST_OK) &&
         (rsp_payload.channel_index == 2'($past(rsp_payload.channel_index) + 2'd1)) &&
         (rsp_payload.accuracy_out == $past(rsp_payload.accuracy_out)))
      else $error("channel sequence broken");

   // a report end cannot pass while results are blocked
   a_last_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall && req_valid && req_payload.last_byte |-> req_stall)
      else $error("last byte taken while results pending");

endmodule

bind protobuf_sensor_report_parser psrp_checker u_checker (.*);

`default_nettype wire
